@@ design/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg
// shared types and constants for the riff chunk search block
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // 'L','I','S','T' packed little-endian
  localparam logic [31:0] LIST_FOURCC = 32'h5453_494C;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // apb register map
  localparam int          CFG_ADDR_W     = 3;
  localparam logic        REG_TARGET_ID  = 1'b0;
  localparam logic        REG_START_OFFS = 1'b1;

  // one classified stream beat
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // configuration seen by the back part
  typedef struct packed {
    logic [31:0] target_id;
    logic [31:0] start_offset;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/rcs_front.sv @@
// ----------------------------------------------------------------------------
// rcs_front
// apb register file and input beat classification
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_front
  import rcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // input channel
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_first_byte,
  input  wire logic                  in_last_byte,
  // queue side
  input  wire logic                  q_full,
  output logic                       push,
  output item_t                      push_item,
  output cfg_t                       cfg
);

  logic [31:0] target_r, target_nxt;
  logic [31:0] start_r,  start_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    target_nxt = target_r;
    start_nxt  = start_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_TARGET_ID:  target_nxt = pwdata;
        REG_START_OFFS: start_nxt  = pwdata;
        default:        target_nxt = target_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      start_r  <= '0;
    end else begin
      target_r <= target_nxt;
      start_r  <= start_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TARGET_ID:  prdata = target_r;
      REG_START_OFFS: prdata = start_r;
      default:        prdata = '0;
    endcase
  end

  assign cfg.target_id    = target_r;
  assign cfg.start_offset = start_r;

  // a beat enters whenever the queue has room
  assign push            = in_valid && !q_full;
  assign push_item.data  = in_data_byte;
  assign push_item.first = in_first_byte;
  assign push_item.last  = in_last_byte;

endmodule

`default_nettype wire

@@ design/rcs_queue.sv @@
// ----------------------------------------------------------------------------
// rcs_queue
// small fifo of classified beats between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_queue
  import rcs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       nonempty,
  output item_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= ptr_inc(wptr_r);
      if (pop)  rptr_r <= ptr_inc(rptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/rcs_back.sv @@
// ----------------------------------------------------------------------------
// rcs_back
// chunk walker: word assembly, id compare, body skip, result register
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_back
  import rcs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  cfg_t              cfg,
  input  wire logic         q_nonempty,
  input  item_t             q_head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_found,
  output logic [31:0]       out_match_offset
);

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_SIZE  = 2'd1,
    PH_LTYPE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_c;
  logic [1:0]  bcnt_r,  bcnt_nxt,  bcnt_c;
  logic [31:0] word_r,  word_nxt,  word_c;
  logic [32:0] skip_r,  skip_nxt,  skip_c;
  logic [31:0] pos_r,   pos_nxt,   pos_c;
  logic        fin_r,   fin_nxt,   fin_c;
  logic        ovld_r;
  logic        found_r;
  logic [31:0] offs_r;
  logic        emit, hit;
  logic [32:0] size_even;

  assign pop = q_nonempty && (!ovld_r || !out_stall);

  assign size_even = ({1'b0, word_nxt} + 33'd1) & ~33'd1;

  always_comb begin
    // a first mark restarts the walk before the beat is used
    if (q_head.first) begin
      phase_c = PH_ID;
      bcnt_c  = '0;
      word_c  = '0;
      skip_c  = '0;
      pos_c   = cfg.start_offset;
      fin_c   = 1'b0;
    end else begin
      phase_c = phase_r;
      bcnt_c  = bcnt_r;
      word_c  = word_r;
      skip_c  = skip_r;
      pos_c   = pos_r;
      fin_c   = fin_r;
    end
    phase_nxt = phase_c;
    bcnt_nxt  = bcnt_c;
    word_nxt  = word_c;
    skip_nxt  = skip_c;
    pos_nxt   = pos_c;
    fin_nxt   = fin_c;
    emit      = 1'b0;
    hit       = 1'b0;
    if (!fin_c) begin
      pos_nxt = pos_c + 32'd1;
      if (phase_c == PH_SKIP) begin
        skip_nxt = skip_c - 33'd1;
        if (skip_nxt == '0) phase_nxt = PH_ID;
      end else begin
        word_nxt = {q_head.data, word_c[31:8]};
        bcnt_nxt = bcnt_c + 2'd1;
        if (bcnt_nxt == 2'd0) begin
          unique case (phase_c)
            PH_ID: begin
              if (word_nxt == cfg.target_id) begin
                emit = 1'b1;
                hit  = 1'b1;
              end else begin
                skip_nxt  = {32'd0, (word_nxt == LIST_FOURCC)};
                phase_nxt = PH_SIZE;
              end
            end
            PH_SIZE: begin
              if (skip_c != '0) begin
                skip_nxt  = '0;
                phase_nxt = PH_LTYPE;
              end else begin
                skip_nxt  = size_even;
                phase_nxt = (size_even != '0) ? PH_SKIP : PH_ID;
              end
            end
            PH_LTYPE: begin
              if (word_nxt == cfg.target_id) begin
                emit = 1'b1;
                hit  = 1'b1;
              end else begin
                phase_nxt = PH_ID;
              end
            end
            default: phase_nxt = PH_ID;
          endcase
        end
      end
      if (!emit && q_head.last) emit = 1'b1;
      if (emit) fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      bcnt_r  <= '0;
      word_r  <= '0;
      skip_r  <= '0;
      pos_r   <= '0;
      fin_r   <= 1'b1;
      ovld_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        bcnt_r  <= bcnt_nxt;
        word_r  <= word_nxt;
        skip_r  <= skip_nxt;
        pos_r   <= pos_nxt;
        fin_r   <= fin_nxt;
      end
      if (pop && emit) begin
        ovld_r  <= 1'b1;
        found_r <= hit;
        offs_r  <= hit ? pos_nxt : 32'd0;
      end else if (!out_stall) begin
        ovld_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = ovld_r;
  assign out_found        = found_r;
  assign out_match_offset = offs_r;

endmodule

`default_nettype wire

@@ design/riff_chunk_search.sv @@
// ----------------------------------------------------------------------------
// riff_chunk_search
// scans a riff byte stream for a fourcc as chunk id or list type
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | in_valid / in_stall        | in_data_byte, in_first_byte,
//           |                            | in_last_byte
//  out      | out_valid / out_stall      | out_found, out_match_offset
//  cfg      | psel penable pwrite pready | paddr, pwdata, prdata
//
//  one byte beat per clock sustained while no result is held by out_stall;
//  the chunk walker in the back part handles one beat each cycle, its 33-bit
//  skip counter update and id compare are combinational
//  a result appears on out in the cycle after its byte leaves the queue
//  synchronous active-low reset; no clearing pass, the walker idles until
//  the first first-byte mark
//  in_stall rises only when the queue is full, which takes a stall on out
//  held while the result register is occupied
// ----------------------------------------------------------------------------
`default_nettype none

module riff_chunk_search
  import rcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // byte stream
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_first_byte,
  input  wire logic                  in_last_byte,
  // search result
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_found,
  output logic [31:0]                out_match_offset
);

  // front to queue
  logic  push;
  item_t push_item;
  cfg_t  cfg;

  // queue to back
  logic  q_full;
  logic  q_nonempty;
  item_t q_head;
  logic  pop;

  assign in_stall = q_full;

  // register file and beat classification
  rcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // decouples the input side from result backpressure
  rcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // chunk walker and result register
  rcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

endmodule

`default_nettype wire

@@ design/rcs_checker.sv @@
// ----------------------------------------------------------------------------
// rcs_checker
// port-level checks for riff_chunk_search
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        pready,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_found,
  input wire logic [31:0] out_match_offset
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_match_offset))
    else $error("result beat changed while stalled");

  // not-found results carry a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == 32'd0)
    else $error("not-found result with nonzero offset");

  // reset empties the result register and the queue
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall left over after reset");

  // input backpressure only builds while results are held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind riff_chunk_search rcs_checker u_rcs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .pready           (pready),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_match_offset (out_match_offset)
);

`default_nettype wire

@@ dv/tb_riff_chunk_search.sv @@
// ----------------------------------------------------------------------------
// tb_riff_chunk_search
// self-checking bench: streams riff-shaped byte sequences with random content,
// walks the chunk structure alongside the block and compares every search
// result (found flag and match offset) in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_riff_chunk_search
  import rcs_pkg::*;
();

  // register byte addresses on the apb port
  localparam logic [CFG_ADDR_W-1:0] ADDR_TARGET = {REG_TARGET_ID, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_START  = {REG_START_OFFS, 2'b00};

  // fourcc codes, little-endian packed
  localparam logic [31:0] FCC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] FCC_DATA = 32'h6174_6164;
  localparam logic [31:0] FCC_INFO = 32'h4F46_4E49;
  localparam logic [31:0] FCC_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;

  // settle time after a drain covers the queue plus result register
  localparam int SETTLE       = QUEUE_DEPTH_DEF + 8;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RANDOM_BEATS = 1400;

  typedef enum logic [1:0] {WK_ID, WK_SIZE, WK_LTYPE, WK_SKIP} walk_phase_e;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } search_hit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [31:0] out_match_offset;

  riff_chunk_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_offset (out_match_offset)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // chunk walker mirror: register copies and walk state
  // --------------------------------------------------------------------------
  logic [31:0] cf_target = '0;
  logic [31:0] cf_start = '0;

  walk_phase_e wk_phase = WK_ID;
  logic [1:0]  wk_nbytes = '0;
  logic [31:0] wk_shift = '0;
  logic [32:0] wk_skip = '0;     // doubles as the list flag while the size is read
  logic [31:0] wk_pos = '0;
  logic        wk_done = 1'b1;   // idle until the first first-byte mark

  search_hit_t pending_hits[$];  // results still owed by the block
  item_t       beats[$];         // stream under construction

  int err_count = 0;
  int live_beats = 0;            // beats accepted by the block

  // sender burst control
  bit gaps_on = 1'b0;
  int burst_left = 0;

  // receiver stall control
  bit stall_on = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  bit stall_lvl = 1'b0;
  int run_left = 0;

  // one byte through the walker; returns 1 when a search result falls out
  function automatic bit walk_byte(input logic [7:0] b, input logic first,
                                   input logic last, output search_hit_t hit);
    logic [31:0] w;
    hit = '0;
    // a first mark restarts the walk at the configured offset
    if (first) begin
      wk_phase  = WK_ID;
      wk_nbytes = '0;
      wk_shift  = '0;
      wk_skip   = '0;
      wk_pos    = cf_start;
      wk_done   = 1'b0;
    end
    if (wk_done) return 1'b0;
    wk_pos = wk_pos + 32'd1;
    if (wk_phase == WK_SKIP) begin
      wk_skip = wk_skip - 33'd1;
      if (wk_skip == '0) wk_phase = WK_ID;
    end else begin
      wk_shift  = {b, wk_shift[31:8]};
      wk_nbytes = wk_nbytes + 2'd1;
      if (wk_nbytes == 2'd0) begin
        w = wk_shift;
        case (wk_phase)
          WK_ID: begin
            if (w == cf_target) begin
              hit.found  = 1'b1;
              hit.offset = wk_pos;
              wk_done    = 1'b1;
              return 1'b1;
            end
            wk_skip  = (w == LIST_FOURCC) ? 33'd1 : 33'd0;
            wk_phase = WK_SIZE;
          end
          WK_SIZE: begin
            if (wk_skip != '0) begin
              wk_skip  = '0;
              wk_phase = WK_LTYPE;
            end else begin
              // body length rounded up to even, all-ones size gives 2^32
              wk_skip  = ({1'b0, w} + 33'd1) & ~33'd1;
              wk_phase = (wk_skip != '0) ? WK_SKIP : WK_ID;
            end
          end
          default: begin
            // list type compare, then descend into the list
            if (w == cf_target) begin
              hit.found  = 1'b1;
              hit.offset = wk_pos;
              wk_done    = 1'b1;
              return 1'b1;
            end
            wk_phase = WK_ID;
          end
        endcase
      end
    end
    if (last) begin
      wk_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every accepted result beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    search_hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result beat: found %0d match_offset 0x%08h",
               out_found, out_match_offset);
        err_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d got %0d", want.found, out_found);
          err_count++;
        end
        if (out_match_offset !== want.offset) begin
          $error("match_offset: expected 0x%08h got 0x%08h", want.offset,
                 out_match_offset);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: long hold-off on request, else free or alternating stall/free runs
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stall_lvl = !stall_lvl;
        run_left  = stall_lvl ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end
      run_left--;
      out_stall <= stall_lvl;
    end
  end

  // --------------------------------------------------------------------------
  // sender side helpers
  // --------------------------------------------------------------------------
  // offer one beat and hold it until accepted, then account for it
  task automatic send_beat(input item_t it);
    search_hit_t hit;
    in_valid      <= 1'b1;
    in_data_byte  <= it.data;
    in_first_byte <= it.first;
    in_last_byte  <= it.last;
    do @(posedge clk); while (in_stall);
    live_beats++;
    if (walk_byte(it.data, it.first, it.last, hit)) pending_hits.push_back(hit);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // send the whole stream buffer, in random bursts when gaps are on; valid is left high and a
  // gap or a drain lowers it afterwards, unless the next beat follows straight on
  task automatic play_beats();
    foreach (beats[i]) begin
      if (gaps_on && burst_left == 0) begin
        idle_gap($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      send_beat(beats[i]);
    end
    beats.delete();
  endtask

  // wait until every owed result is in, then let the pipeline settle
  task automatic drain_results(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_hits.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_hits.size() != 0) begin
      $error("%0d search results never arrived", pending_hits.size());
      err_count++;
      pending_hits.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write: setup then access, register lands when pready is high
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TARGET) cf_target = val;
    else cf_start = val;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // stream construction
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it.data  = b;
    it.first = 1'b0;
    it.last  = 1'b0;
    beats.push_back(it);
  endtask

  task automatic push_word(input logic [31:0] w);
    push_byte(w[7:0]);
    push_byte(w[15:8]);
    push_byte(w[23:16]);
    push_byte(w[31:24]);
  endtask

  task automatic mark_beat(input int idx, input logic f, input logic l);
    item_t it;
    it       = beats[idx];
    it.first = it.first | f;
    it.last  = it.last | l;
    beats[idx] = it;
  endtask

  function automatic logic [31:0] pool_fourcc();
    case ($urandom_range(0, 4))
      0: return FCC_FMT;
      1: return FCC_DATA;
      2: return FCC_INFO;
      3: return FCC_JUNK;
      default: return FCC_MOVI;
    endcase
  endfunction

  // chunk ids lean on the target so that hits are frequent
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 5))
      0: return cf_target;
      1: return LIST_FOURCC;
      2: return $urandom;
      default: return pool_fourcc();
    endcase
  endfunction

  // ordinary chunk: id, size, body padded to even length
  task automatic push_plain();
    logic [31:0] sz;
    int body;
    if ($urandom_range(0, 15) == 0) sz = 32'hFFFF_FFFF;
    else if ($urandom_range(0, 7) == 0) sz = '0;
    else sz = $urandom_range(1, 11);
    push_word(pick_id());
    push_word(sz);
    // an all-ones size can never be skipped here, stream runs out inside it
    body = (sz == 32'hFFFF_FFFF) ? 0 : ((int'(sz) + 1) & ~1);
    repeat (body) push_byte(8'($urandom));
  endtask

  // list chunk: LIST, size, list type, then up to two ordinary chunks
  task automatic push_list();
    int subs;
    subs = $urandom_range(0, 2);
    push_word(LIST_FOURCC);
    push_word($urandom_range(4, 40));
    push_word(pick_id());
    repeat (subs) push_plain();
  endtask

  task automatic build_random_stream();
    int n_chunks;
    int cut;
    int k;
    item_t it;
    beats.delete();
    if ($urandom_range(0, 9) == 0) begin
      // pure noise with random marks, may start unmarked and be ignored
      repeat ($urandom_range(4, 16)) begin
        push_byte(8'($urandom));
        mark_beat(beats.size() - 1, $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) == 0);
      end
      return;
    end
    n_chunks = $urandom_range(1, 5);
    repeat (n_chunks) begin
      if ($urandom_range(0, 3) == 0) push_list();
      else push_plain();
    end
    mark_beat(0, 1'b1, 1'b0);
    mark_beat(beats.size() - 1, 1'b0, 1'b1);
    case ($urandom_range(0, 9))
      0: begin
        // truncated stream, ends anywhere inside a word or a body
        cut = $urandom_range(1, beats.size());
        while (beats.size() > cut) beats.delete(beats.size() - 1);
        mark_beat(beats.size() - 1, 1'b0, 1'b1);
      end
      1: mark_beat($urandom_range(1, beats.size() - 1), 1'b1, 1'b0);
      2: begin
        // trailing bytes after the end, no first mark
        repeat ($urandom_range(1, 6)) begin
          push_byte(8'($urandom));
          mark_beat(beats.size() - 1, 1'b0, 1'($urandom_range(0, 1)));
        end
      end
      3: begin
        // corrupt one byte, usually throws the walk out of step
        k = $urandom_range(0, beats.size() - 1);
        it = beats[k];
        it.data = 8'($urandom);
        beats[k] = it;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    item_t it;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    cfg_write(ADDR_TARGET, LIST_FOURCC);
    cfg_write(ADDR_START, 32'h0000_0000);

    // stray byte before any first mark is ignored
    it.data  = 8'hFF;
    it.first = 1'b0;
    it.last  = 1'b1;
    send_beat(it);

    // target equal to LIST hits as chunk id, and on the last byte
    push_word(LIST_FOURCC);
    mark_beat(0, 1'b1, 1'b0);
    mark_beat(3, 1'b0, 1'b1);
    play_beats();
    drain_results(DRAIN_LIMIT);

    // zero-size chunk, then descent into a list; offset wraps past 2^32
    cfg_write(ADDR_TARGET, FCC_FMT);
    cfg_write(ADDR_START, 32'hFFFF_FFFE);
    push_word(FCC_JUNK);
    push_word(32'h0000_0000);
    push_word(LIST_FOURCC);
    push_word(32'hFFFF_FFFF);
    push_word(FCC_FMT);
    mark_beat(0, 1'b1, 1'b0);
    play_beats();
    drain_results(DRAIN_LIMIT);

    // all-ones size, new first mark inside the skip, end inside a word
    push_word(FCC_DATA);
    push_word(32'hFFFF_FFFF);
    push_byte(8'h00);
    push_byte(8'h5A);
    push_byte(8'h00);
    mark_beat(0, 1'b1, 1'b0);
    mark_beat(9, 1'b1, 1'b0);
    mark_beat(10, 1'b0, 1'b1);
    play_beats();
    drain_results(DRAIN_LIMIT);
  endtask

  task automatic pick_config(input int phase_no);
    logic [31:0] tgt;
    logic [31:0] st;
    case (phase_no)
      0: begin
        tgt = 32'h0000_0000;
        st  = 32'hFFFF_FFFF;
      end
      1: begin
        tgt = 32'hFFFF_FFFF;
        st  = 32'h0000_0000;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: tgt = $urandom;
          1: tgt = LIST_FOURCC;
          default: tgt = pool_fourcc();
        endcase
        case ($urandom_range(0, 3))
          0: st = 32'h0000_0000;
          1: st = 32'hFFFF_FFF8;
          default: st = $urandom;
        endcase
      end
    endcase
    cfg_write(ADDR_TARGET, tgt);
    cfg_write(ADDR_START, st);
  endtask

  task automatic test_random_streams();
    int base;
    int phase_no;
    base     = live_beats;
    phase_no = 0;
    while (live_beats - base < RANDOM_BEATS) begin
      // reconfigure now and then, only with the block drained
      if (phase_no < 2 || $urandom_range(0, 5) == 0) begin
        drain_results(DRAIN_LIMIT);
        pick_config(phase_no);
        phase_no++;
      end
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 2) != 0);
      build_random_stream();
      play_beats();
    end
    drain_results(DRAIN_LIMIT);
  endtask

  // long receiver hold-off while the sender keeps offering one-byte streams,
  // each giving a result, so the queue fills and in_stall rises
  task automatic test_backpressure();
    item_t it;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    hold_req = 300;
    repeat (40) begin
      it.data  = 8'($urandom);
      it.first = 1'b1;
      it.last  = 1'b1;
      send_beat(it);
    end
    // sender stays quiet until every owed result is in
    drain_results(DRAIN_LIMIT);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_backpressure();
    test_random_streams();
    test_backpressure();
    drain_results(DRAIN_LIMIT);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
